// ----- src/ifwp_pkg.sv -----
package ifwp_pkg;

  localparam int NUM_IMUS   = 3;
  localparam int IMU_IDX_W  = (NUM_IMUS > 1) ? $clog2(NUM_IMUS) : 1;
  localparam int WORD_BYTES = 7;
  localparam int TAG_W      = 5;
  localparam int PAYLOAD_W  = 48;
  localparam int CNT_W      = 32;

  localparam logic [2:0] LAST_POS = 3'(WORD_BYTES - 1);

  localparam logic [TAG_W-1:0] GYRO_TAG_RST  = 5'd1;
  localparam logic [TAG_W-1:0] ACCEL_TAG_RST = 5'd2;

  // configuration register indexes
  localparam logic CFG_GYRO_TAG  = 1'b0;
  localparam logic CFG_ACCEL_TAG = 1'b1;

  // request and result kinds
  localparam logic REQ_BYTE   = 1'b0;
  localparam logic REQ_DIAG   = 1'b1;
  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_DIAG  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [1:0] sensor_sel;
    logic [7:0] fifo_byte;
    logic       burst_start;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [1:0]         sensor_index;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [CNT_W-1:0]   reuse_count;
    logic [CNT_W-1:0]   unknown_count;
  } out_item_t;

endpackage

// ----- src/imu_fifo_word_pairer.sv -----
// imu_fifo_word_pairer
//
// Input channel (in_valid / in_stall / in_item): one item per cycle while
// in_stall is low, either one byte of a sensor FIFO burst or a read-and-clear diagnostics request.
// Bytes are framed into 7-byte words (tag byte plus three 16-bit axes).
// A gyro word is held per sensor; an accel word yields one pair item once that sensor has a gyro word.
// Result channel (out_valid / out_stall / out_item): one item per pair or
// diagnostics request, registered in the output register, or in the skid register when the receiver stalls.
// Throughput is one item per cycle while in_stall is low: all state is updated in the accept cycle
// and results go to an output register backed by a one-entry skid register.
// in_stall rises only while the skid register holds an item, i.e. after the
// receiver has stalled with a result waiting and another result arrived.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the gyro
// and accel tag codes; cfg_ready is always high. Write only while idle.
// Reset (rst_n low, synchronous) clears framing, freshness, counters and
// both output slots, and restores tag codes 1 (gyro) and 2 (accel).
module imu_fifo_word_pairer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ifwp_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ifwp_pkg::out_item_t   out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [ifwp_pkg::TAG_W-1:0] cfg_data
);

  localparam int N  = ifwp_pkg::NUM_IMUS;
  localparam int IW = ifwp_pkg::IMU_IDX_W;

  logic [ifwp_pkg::TAG_W-1:0]     gyro_tag_r, accel_tag_r;
  logic [2:0]                     byte_pos_r, byte_pos_nxt;
  logic [ifwp_pkg::TAG_W-1:0]     word_tag_r, word_tag_nxt;
  logic [ifwp_pkg::PAYLOAD_W-1:0] payload_r, payload_nxt;
  logic [ifwp_pkg::PAYLOAD_W-1:0] pend_gyro_r [N];
  logic [N-1:0]                   seen_r, fresh_r;
  logic [ifwp_pkg::CNT_W-1:0]     reuse_r [N];
  logic [ifwp_pkg::CNT_W-1:0]     bad_r [N];

  logic                out_valid_r, skid_valid_r;
  ifwp_pkg::out_item_t out_r, skid_r;

  logic                in_acc;
  logic                in_range;
  logic [IW-1:0]       sidx;
  logic                is_byte, word_done;
  logic                is_gyro, is_accel;
  logic                res_valid;
  ifwp_pkg::out_item_t res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign in_acc    = in_valid && !in_stall;
  assign in_range  = 32'(in_item.sensor_sel) < 32'(N);
  assign sidx      = IW'(in_item.sensor_sel);
  assign is_byte   = in_acc && (in_item.req_type == ifwp_pkg::REQ_BYTE) && in_range;

  // word framing
  always_comb begin
    byte_pos_nxt = in_item.burst_start ? 3'd0 : byte_pos_r;
    word_tag_nxt = word_tag_r;
    payload_nxt  = payload_r;
    word_done    = 1'b0;
    if (byte_pos_nxt == 3'd0) begin
      word_tag_nxt = in_item.fifo_byte[7:3];
      payload_nxt  = '0;
      byte_pos_nxt = 3'd1;
    end else begin
      payload_nxt[8*(byte_pos_nxt-3'd1) +: 8] = in_item.fifo_byte;
      if (byte_pos_nxt == ifwp_pkg::LAST_POS) begin
        byte_pos_nxt = 3'd0;
        word_done    = 1'b1;
      end else begin
        byte_pos_nxt = byte_pos_nxt + 3'd1;
      end
    end
  end

  assign is_gyro  = word_tag_nxt == gyro_tag_r;
  assign is_accel = !is_gyro && (word_tag_nxt == accel_tag_r);

  // result of the accepted item
  always_comb begin
    res              = '0;
    res.sensor_index = in_item.sensor_sel;
    res_valid        = 1'b0;
    if (in_acc && in_item.req_type == ifwp_pkg::REQ_DIAG) begin
      res_valid       = 1'b1;
      res.result_kind = ifwp_pkg::KIND_DIAG;
      if (in_range) begin
        res.reuse_count   = reuse_r[sidx];
        res.unknown_count = bad_r[sidx];
      end
    end else if (is_byte && word_done && is_accel && seen_r[sidx]) begin
      res_valid       = 1'b1;
      res.result_kind = ifwp_pkg::KIND_PAIR;
      res.gyro_x      = pend_gyro_r[sidx][15:0];
      res.gyro_y      = pend_gyro_r[sidx][31:16];
      res.gyro_z      = pend_gyro_r[sidx][47:32];
      res.accel_x     = payload_nxt[15:0];
      res.accel_y     = payload_nxt[31:16];
      res.accel_z     = payload_nxt[47:32];
    end
  end

  // config and per-sensor control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_tag_r  <= ifwp_pkg::GYRO_TAG_RST;
      accel_tag_r <= ifwp_pkg::ACCEL_TAG_RST;
      byte_pos_r  <= '0;
      word_tag_r  <= '0;
      payload_r   <= '0;
      seen_r      <= '0;
      fresh_r     <= '0;
      for (int i = 0; i < N; i++) begin
        reuse_r[i] <= '0;
        bad_r[i]   <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ifwp_pkg::CFG_GYRO_TAG:  gyro_tag_r  <= cfg_data;
          ifwp_pkg::CFG_ACCEL_TAG: accel_tag_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && in_item.req_type == ifwp_pkg::REQ_DIAG && in_range) begin
        reuse_r[sidx] <= '0;
        bad_r[sidx]   <= '0;
      end
      if (is_byte) begin
        byte_pos_r <= byte_pos_nxt;
        word_tag_r <= word_tag_nxt;
        payload_r  <= payload_nxt;
        if (word_done) begin
          if (is_gyro) begin
            seen_r[sidx]  <= 1'b1;
            fresh_r[sidx] <= 1'b1;
          end else if (is_accel) begin
            if (seen_r[sidx]) begin
              fresh_r[sidx] <= 1'b0;
              if (!fresh_r[sidx]) reuse_r[sidx] <= reuse_r[sidx] + 1'b1;
            end
          end else begin
            bad_r[sidx] <= bad_r[sidx] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_byte && word_done && is_gyro) begin
      pend_gyro_r[sidx] <= payload_nxt;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_stall) skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      if (!out_valid_r || !out_stall) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (!out_stall) out_r <= skid_r;
    end else if (res_valid) begin
      if (!out_valid_r || !out_stall) out_r <= res;
      else skid_r <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output is empty");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= ifwp_pkg::LAST_POS)
    else $error("byte position beyond word length");

  a_fresh_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (fresh_r & ~seen_r) == '0)
    else $error("gyro fresh without gyro seen");

  a_diag_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.req_type == ifwp_pkg::REQ_DIAG) |=> out_valid_r)
    else $error("diagnostics request produced no result");

endmodule

// ----- dv/imu_fifo_word_pairer_checker.sv -----
module imu_fifo_word_pairer_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  ifwp_pkg::in_item_t           in_item,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  ifwp_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [ifwp_pkg::TAG_W-1:0]   cfg_data,
  output int                           mismatches,
  output int                           backlog
);

  logic [ifwp_pkg::TAG_W-1:0]     gyro_code;
  logic [ifwp_pkg::TAG_W-1:0]     accel_code;
  logic [2:0]                     byte_pos;
  logic [ifwp_pkg::TAG_W-1:0]     cur_tag;
  logic [ifwp_pkg::PAYLOAD_W-1:0] cur_axes;
  logic [ifwp_pkg::PAYLOAD_W-1:0] held_gyro [ifwp_pkg::NUM_IMUS];
  bit                             gyro_valid [ifwp_pkg::NUM_IMUS];
  bit                             gyro_fresh [ifwp_pkg::NUM_IMUS];
  logic [ifwp_pkg::CNT_W-1:0]     reuse_total [ifwp_pkg::NUM_IMUS];
  logic [ifwp_pkg::CNT_W-1:0]     unknown_total [ifwp_pkg::NUM_IMUS];
  ifwp_pkg::out_item_t            results_due [$];

  initial begin
    mismatches = 0;
    backlog = 0;
  end

  task automatic absorb_item(input ifwp_pkg::in_item_t it);
    ifwp_pkg::out_item_t r;
    int s;
    int sh;
    r = '0;
    s = int'(it.sensor_sel);
    if (it.req_type == ifwp_pkg::REQ_DIAG) begin
      r.result_kind = ifwp_pkg::KIND_DIAG;
      r.sensor_index = it.sensor_sel;
      if (s < ifwp_pkg::NUM_IMUS) begin
        r.reuse_count = reuse_total[s];
        r.unknown_count = unknown_total[s];
        reuse_total[s] = '0;
        unknown_total[s] = '0;
      end
      results_due.push_back(r);
    end else if (s < ifwp_pkg::NUM_IMUS) begin
      if (it.burst_start) byte_pos = '0;
      if (byte_pos == 0) begin
        cur_tag = it.fifo_byte[7:3];
        cur_axes = '0;
        byte_pos = 3'd1;
      end else begin
        sh = 8 * (int'(byte_pos) - 1);
        cur_axes[sh +: 8] = it.fifo_byte;
        if (byte_pos < ifwp_pkg::LAST_POS) begin
          byte_pos = byte_pos + 3'd1;
        end else begin
          byte_pos = '0;
          // gyro wins when both codes match
          if (cur_tag == gyro_code) begin
            held_gyro[s] = cur_axes;
            gyro_valid[s] = 1'b1;
            gyro_fresh[s] = 1'b1;
          end else if (cur_tag == accel_code) begin
            if (gyro_valid[s]) begin
              if (!gyro_fresh[s]) reuse_total[s] = reuse_total[s] + 1'b1;
              gyro_fresh[s] = 1'b0;
              r.result_kind = ifwp_pkg::KIND_PAIR;
              r.sensor_index = it.sensor_sel;
              r.gyro_x = held_gyro[s][15:0];
              r.gyro_y = held_gyro[s][31:16];
              r.gyro_z = held_gyro[s][47:32];
              r.accel_x = cur_axes[15:0];
              r.accel_y = cur_axes[31:16];
              r.accel_z = cur_axes[47:32];
              results_due.push_back(r);
            end
          end else begin
            unknown_total[s] = unknown_total[s] + 1'b1;
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    ifwp_pkg::out_item_t want;
    if (!rst_n) begin
      gyro_code = ifwp_pkg::GYRO_TAG_RST;
      accel_code = ifwp_pkg::ACCEL_TAG_RST;
      byte_pos = '0;
      cur_tag = '0;
      cur_axes = '0;
      for (int i = 0; i < ifwp_pkg::NUM_IMUS; i++) begin
        held_gyro[i] = '0;
        gyro_valid[i] = 1'b0;
        gyro_fresh[i] = 1'b0;
        reuse_total[i] = '0;
        unknown_total[i] = '0;
      end
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ifwp_pkg::CFG_GYRO_TAG: gyro_code = cfg_data;
          ifwp_pkg::CFG_ACCEL_TAG: accel_code = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("unexpected result item: kind %0h sensor %0h",
                 out_item.result_kind, out_item.sensor_index);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_item.result_kind));
          check_field("sensor_index", 32'(want.sensor_index), 32'(out_item.sensor_index));
          check_field("gyro_x", 32'(want.gyro_x), 32'(out_item.gyro_x));
          check_field("gyro_y", 32'(want.gyro_y), 32'(out_item.gyro_y));
          check_field("gyro_z", 32'(want.gyro_z), 32'(out_item.gyro_z));
          check_field("accel_x", 32'(want.accel_x), 32'(out_item.accel_x));
          check_field("accel_y", 32'(want.accel_y), 32'(out_item.accel_y));
          check_field("accel_z", 32'(want.accel_z), 32'(out_item.accel_z));
          check_field("reuse_count", want.reuse_count, out_item.reuse_count);
          check_field("unknown_count", want.unknown_count, out_item.unknown_count);
        end
      end
      if (in_valid && !in_stall) absorb_item(in_item);
    end
    backlog = results_due.size();
  end

endmodule

// ----- dv/imu_fifo_word_pairer_test.sv -----
module imu_fifo_word_pairer_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 180;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  ifwp_pkg::in_item_t         in_item = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  ifwp_pkg::out_item_t        out_item;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index = 1'b0;
  logic [ifwp_pkg::TAG_W-1:0] cfg_data = '0;

  int                         mismatches;
  int                         backlog;
  int                         cycle_count = 0;
  int                         items_sent = 0;
  int                         send_idle_pct = 30;
  int                         stall_pct = 53;
  logic [ifwp_pkg::TAG_W-1:0] gyro_code = ifwp_pkg::GYRO_TAG_RST;
  logic [ifwp_pkg::TAG_W-1:0] accel_code = ifwp_pkg::ACCEL_TAG_RST;

  imu_fifo_word_pairer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  imu_fifo_word_pairer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input ifwp_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_diag(input logic [1:0] sensor);
    ifwp_pkg::in_item_t it;
    it.req_type = ifwp_pkg::REQ_DIAG;
    it.sensor_sel = sensor;
    it.fifo_byte = 8'($urandom);
    it.burst_start = 1'($urandom);
    send_item(it);
  endtask

  task automatic send_stray_byte(input logic start);
    ifwp_pkg::in_item_t it;
    it.req_type = ifwp_pkg::REQ_BYTE;
    it.sensor_sel = 2'(3);
    it.fifo_byte = 8'($urandom);
    it.burst_start = start;
    send_item(it);
  endtask

  // bytes from_byte..to_byte-1 of one word; noise_pct mixes in stray items
  task automatic send_word(input logic [1:0] sensor, input logic [ifwp_pkg::TAG_W-1:0] tag,
                           input logic [ifwp_pkg::PAYLOAD_W-1:0] axes, input int from_byte,
                           input int to_byte, input logic lead_start, input int noise_pct);
    ifwp_pkg::in_item_t it;
    for (int k = from_byte; k < to_byte; k++) begin
      if ($urandom_range(99) < noise_pct) send_stray_byte(1'($urandom));
      if ($urandom_range(99) < noise_pct) send_diag(2'($urandom));
      it.req_type = ifwp_pkg::REQ_BYTE;
      it.sensor_sel = ($urandom_range(99) < noise_pct)
                      ? 2'($urandom_range(ifwp_pkg::NUM_IMUS - 1)) : sensor;
      it.fifo_byte = (k == 0) ? {tag, 3'($urandom)} : axes[8*(k-1) +: 8];
      it.burst_start = (k == from_byte) ? lead_start : 1'b0;
      send_item(it);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (backlog != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tag_codes(input logic [ifwp_pkg::TAG_W-1:0] g,
                               input logic [ifwp_pkg::TAG_W-1:0] a);
    cfg_valid <= 1'b1;
    cfg_index <= ifwp_pkg::CFG_GYRO_TAG;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= ifwp_pkg::CFG_ACCEL_TAG;
    cfg_data <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gyro_code = g;
    accel_code = a;
  endtask

  initial begin
    int                             pick;
    int                             last_byte;
    int                             target;
    logic [1:0]                     sensor;
    logic [ifwp_pkg::TAG_W-1:0]     tag;
    logic [ifwp_pkg::TAG_W-1:0]     g;
    logic [ifwp_pkg::TAG_W-1:0]     a;
    logic [ifwp_pkg::PAYLOAD_W-1:0] axes;
    ifwp_pkg::in_item_t             junk;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: diag of absent sensor, accel before gyro, extremes, split word
    send_diag(2'(3));
    send_word(2'd0, accel_code, 48'h7fff_0000_8000, 0, 7, 1'b1, 0);
    send_word(2'd0, gyro_code, 48'h8000_ffff_7fff, 0, 7, 1'b1, 0);
    send_word(2'd0, accel_code, 48'hffff_7fff_0000, 0, 3, 1'b1, 0);
    send_stray_byte(1'b1);
    send_diag(2'd0);
    send_word(2'd0, accel_code, 48'hffff_7fff_0000, 3, 7, 1'b0, 0);
    send_diag(2'd0);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin g = 5'd0; a = 5'd31; end
        1: begin g = 5'd31; a = 5'd0; end
        2: begin g = 5'd9; a = 5'd9; end
        4: begin g = ifwp_pkg::GYRO_TAG_RST; a = ifwp_pkg::ACCEL_TAG_RST; end
        default: begin g = 5'($urandom); a = 5'($urandom); end
      endcase
      set_tag_codes(g, a);
      if (ph < 2) begin
        send_idle_pct = 30;
        stall_pct = 53;
      end else if (ph < 4) begin
        send_idle_pct = 53;
        stall_pct = 30;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 78) begin
          sensor = 2'($urandom_range(ifwp_pkg::NUM_IMUS - 1));
          case ($urandom_range(9))
            0, 1, 2, 3: tag = gyro_code;
            4, 5, 6, 7: tag = accel_code;
            default: tag = 5'($urandom);
          endcase
          if ($urandom_range(9) == 0)
            axes = {3{$urandom_range(1) ? 16'h8000 : 16'h7fff}};
          else
            axes = {16'($urandom), 32'($urandom)};
          last_byte = ($urandom_range(99) < 8) ? $urandom_range(1, 6) : 7;
          send_word(sensor, tag, axes, 0, last_byte, $urandom_range(99) < 90, 4);
        end else if (pick < 90) begin
          send_diag(2'($urandom));
        end else begin
          junk.req_type = ifwp_pkg::REQ_BYTE;
          junk.sensor_sel = 2'($urandom);
          junk.fifo_byte = 8'($urandom);
          junk.burst_start = 1'($urandom);
          send_item(junk);
        end
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
